>>> design/rhsv_pkg.sv
// Package with the shared types, constants and divider step for the RGB to HSV converter.
`default_nettype none

package rhsv_pkg;

   // Widths of the pixel channels and of the division datapath.
   localparam int CHAN_W     = 8;
   localparam int HUE_W      = 15;
   localparam int SAT_W      = 17;
   localparam int DIVIDEND_W = 24;
   localparam int DEN_W      = 9;
   localparam int REM_W      = DEN_W;
   localparam int QUO_W      = 18;
   localparam int DIV_STEPS  = 3;
   localparam int DIV_STAGES = QUO_W / DIV_STEPS;

   // Hue angles in units of 1/64 degree.
   localparam logic [HUE_W-1:0] HUE_SIXTY = 15'd3840;
   localparam logic [HUE_W-1:0] HUE_GREEN = 15'd7680;
   localparam logic [HUE_W-1:0] HUE_BLUE  = 15'd15360;
   localparam logic [HUE_W-1:0] HUE_FULL  = 15'd23040;

   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } rgb_type;

   typedef struct packed {
      logic [HUE_W-1:0]  hue_out;
      logic [SAT_W-1:0]  sat_out;
      logic [CHAN_W-1:0] value_out;
   } hsv_type;

   // One restoring division in flight: the partial remainder, the dividend bits still
   // to be consumed (quotient bits shift in from the bottom) and the divisor.
   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] bits;
      logic [DEN_W-1:0] den;
   } div_lane_type;

   typedef struct packed {
      div_lane_type      hue;
      div_lane_type      sat;
      logic [CHAN_W-1:0] value;
   } div_type;

   // One step of restoring division: bring down one dividend bit, subtract if it fits.
   function automatic div_lane_type div_step(input div_lane_type lane);
      div_lane_type    result;
      logic [REM_W:0]  trial;
      logic            fits;
      result = lane;
      trial  = {lane.rem, lane.bits[QUO_W-1]};
      fits   = (trial >= {1'b0, lane.den});
      if (fits) begin
         result.rem = REM_W'(trial - {1'b0, lane.den});
      end else begin
         result.rem = REM_W'(trial);
      end
      result.bits = {lane.bits[QUO_W-2:0], fits};
      return result;
   endfunction

endpackage

`default_nettype wire

>>> design/rgb_to_hsv_convert.sv
// Top level of the pipelined RGB to HSV pixel converter.
//
//   Channel | Ports                                | Carries
//   --------+--------------------------------------+----------------------------------
//   input   | req_valid, req_stall, req_data       | one RGB pixel (rgb_type)
//   result  | rsp_valid, rsp_stall, rsp_data       | hue, saturation, value (hsv_type)
//
// The converter takes one pixel per clock while the result side does not stall, and
// passes it through registered stages: one stage finds max, min and the hue sector, one
// forms the two dividends, and six stages run the two restoring dividers at three quotient bits each.
// Every stage carries its own valid bit and loads whenever it is empty or the stage
// after it moves, so bubbles close up and a stall on the result side loses nothing.
// A synchronous reset clears the valid bits only; the data registers need no reset.
`default_nettype none

module rgb_to_hsv_convert
   import rhsv_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire rgb_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output hsv_type      rsp_data
);

   // Stage A: max, min and the hue sector.
   logic              a_valid_ff;
   logic [CHAN_W-1:0] a_max_ff, a_max_in;
   logic [CHAN_W-1:0] a_delta_ff, a_delta_in;
   logic [CHAN_W-1:0] a_diff_ff, a_diff_in;
   logic              a_neg_ff, a_neg_in;
   logic [HUE_W-1:0]  a_base_ff, a_base_in;
   logic [CHAN_W-1:0] min_val;
   logic              a_load;

   // Stage B: dividends and divisors.
   logic              b_valid_ff;
   div_type           b_data_ff, b_data_in;
   logic              b_load;
   logic [22:0]       base_prod;
   logic [22:0]       diff_prod;
   logic [22:0]       hue_num;

   // Divider stages.
   logic [DIV_STAGES-1:0] d_valid;
   div_type               d_data [DIV_STAGES];
   logic [DIV_STAGES-1:0] d_load;

   logic [QUO_W-1:0] hue_quo;
   logic [QUO_W-1:0] hue_wrap;

   // Each stage moves when it is empty or the next stage moves too.
   always_comb begin
      d_load[DIV_STAGES-1] = !d_valid[DIV_STAGES-1] || !rsp_stall;
      for (int i = DIV_STAGES - 2; i >= 0; i--) begin
         d_load[i] = !d_valid[i] || d_load[i+1];
      end
   end

   assign b_load    = !b_valid_ff || d_load[0];
   assign a_load    = !a_valid_ff || b_load;
   assign req_stall = !a_load;

   // Stage A logic. Ties for the largest channel go to red, then green.
   always_comb begin
      a_max_in = req_data.red_in;
      if (req_data.green_in > a_max_in) a_max_in = req_data.green_in;
      if (req_data.blue_in > a_max_in)  a_max_in = req_data.blue_in;
      min_val = req_data.red_in;
      if (req_data.green_in < min_val) min_val = req_data.green_in;
      if (req_data.blue_in < min_val)  min_val = req_data.blue_in;
      a_delta_in = a_max_in - min_val;

      if (req_data.red_in == a_max_in) begin
         // Red sector: a negative offset wraps around from 360 degrees.
         a_neg_in  = req_data.green_in < req_data.blue_in;
         a_base_in = a_neg_in ? HUE_FULL : '0;
         a_diff_in = a_neg_in ? req_data.blue_in - req_data.green_in
                              : req_data.green_in - req_data.blue_in;
      end else if (req_data.green_in == a_max_in) begin
         a_neg_in  = req_data.blue_in < req_data.red_in;
         a_base_in = HUE_GREEN;
         a_diff_in = a_neg_in ? req_data.red_in - req_data.blue_in
                              : req_data.blue_in - req_data.red_in;
      end else begin
         a_neg_in  = req_data.red_in < req_data.green_in;
         a_base_in = HUE_BLUE;
         a_diff_in = a_neg_in ? req_data.green_in - req_data.red_in
                              : req_data.red_in - req_data.green_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_load) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_max_ff   <= a_max_in;
         a_delta_ff <= a_delta_in;
         a_diff_ff  <= a_diff_in;
         a_neg_ff   <= a_neg_in;
         a_base_ff  <= a_base_in;
      end
   end

   // Stage B logic. The hue numerator is rounded to nearest by dividing
   // (2 * num + delta) by (2 * delta); saturation adds half of max before dividing.
   // Gray and black pixels divide zero by one so that both quotients come out zero.
   assign base_prod = 23'(a_base_ff) * 23'(a_delta_ff);
   assign diff_prod = 23'(HUE_SIXTY) * 23'(a_diff_ff);
   assign hue_num   = a_neg_ff ? base_prod - diff_prod : base_prod + diff_prod;

   always_comb begin
      logic [DIVIDEND_W-1:0] hue_dividend;
      logic [DIVIDEND_W-1:0] sat_dividend;
      logic [DEN_W-1:0]      hue_den;
      logic [DEN_W-1:0]      sat_den;
      hue_dividend = {hue_num, 1'b0} + DIVIDEND_W'(a_delta_ff);
      sat_dividend = {a_delta_ff, 9'b0, a_max_ff[CHAN_W-1:1]};
      hue_den      = {a_delta_ff, 1'b0};
      sat_den      = {1'b0, a_max_ff};
      if (a_delta_ff == '0) begin
         hue_dividend = '0;
         sat_dividend = '0;
         hue_den      = DEN_W'(1);
         sat_den      = DEN_W'(1);
      end
      b_data_in.hue.rem  = REM_W'(hue_dividend[DIVIDEND_W-1:QUO_W]);
      b_data_in.hue.bits = hue_dividend[QUO_W-1:0];
      b_data_in.hue.den  = hue_den;
      b_data_in.sat.rem  = REM_W'(sat_dividend[DIVIDEND_W-1:QUO_W]);
      b_data_in.sat.bits = sat_dividend[QUO_W-1:0];
      b_data_in.sat.den  = sat_den;
      b_data_in.value    = a_max_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_load) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_load) begin
         b_data_ff <= b_data_in;
      end
   end

   // Divider pipeline: each stage retires three quotient bits of both divisions.
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      if (s == 0) begin : g_first
         rhsv_div_stage u_stage (
            .clock     (clock),
            .reset     (reset),
            .load      (d_load[s]),
            .in_valid  (b_valid_ff),
            .in_data   (b_data_ff),
            .out_valid (d_valid[s]),
            .out_data  (d_data[s])
         );
      end else begin : g_next
         rhsv_div_stage u_stage (
            .clock     (clock),
            .reset     (reset),
            .load      (d_load[s]),
            .in_valid  (d_valid[s-1]),
            .in_data   (d_data[s-1]),
            .out_valid (d_valid[s]),
            .out_data  (d_data[s])
         );
      end
   end

   // A full-circle hue folds back to zero.
   assign hue_quo  = d_data[DIV_STAGES-1].hue.bits;
   assign hue_wrap = (hue_quo >= QUO_W'(HUE_FULL)) ? hue_quo - QUO_W'(HUE_FULL) : hue_quo;

   assign rsp_valid          = d_valid[DIV_STAGES-1];
   assign rsp_data.hue_out   = hue_wrap[HUE_W-1:0];
   assign rsp_data.sat_out   = d_data[DIV_STAGES-1].sat.bits[SAT_W-1:0];
   assign rsp_data.value_out = d_data[DIV_STAGES-1].value;

endmodule

`default_nettype wire

>>> design/rhsv_div_stage.sv
// One registered stage of the pipelined hue and saturation dividers.
`default_nettype none

module rhsv_div_stage
   import rhsv_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire logic    in_valid,
   input  wire div_type in_data,
   output logic         out_valid,
   output div_type      out_data
);

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;

   always_comb begin
      data_in = in_data;
      for (int i = 0; i < DIV_STEPS; i++) begin
         data_in.hue = div_step(data_in.hue);
         data_in.sat = div_step(data_in.sat);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire
